// ===== src/priority_queue_server_dispatch_unit_assert.svh =====
// Assertion macros shared by the dispatch unit RTL.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef PRIORITY_QUEUE_SERVER_DISPATCH_UNIT_ASSERT_SVH
`define PRIORITY_QUEUE_SERVER_DISPATCH_UNIT_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define PQSD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define PQSD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define PQSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pqsd_pkg.sv =====
// Shared types and constants of the priority queue server dispatch unit.
// No dependencies; pqsd_srv and the top level import this package.
`default_nettype none

package pqsd_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_SERVERS = 3;

	localparam int QIDX_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int ACCT_W  = 24;
	localparam int REQ_W   = 3;
	localparam int SRV_W   = 2;
	localparam int STAT_W  = 4;
	localparam int COUNT_W = 5;

	localparam logic [SRV_W:0] SRV_LIMIT = NUM_SERVERS[SRV_W:0];

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT    = 3'd0,
		REQ_REMOVE    = 3'd1,
		REQ_CALL_NEXT = 3'd2,
		REQ_RELEASE   = 3'd3,
		REQ_OPEN      = 3'd4,
		REQ_CLOSE     = 3'd5
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_ASSIGNED       = 4'd0,
		ST_QUEUED         = 4'd1,
		ST_REMOVED        = 4'd2,
		ST_NOT_FOUND      = 4'd3,
		ST_EMPTY          = 4'd4,
		ST_NONE_FREE      = 4'd5,
		ST_RELEASED       = 4'd6,
		ST_ALREADY_FREE   = 4'd7,
		ST_CLOSED         = 4'd8,
		ST_OPENED         = 4'd9,
		ST_ALREADY_OPEN   = 4'd10,
		ST_BUSY           = 4'd11,
		ST_CLOSED_OK      = 4'd12,
		ST_ALREADY_CLOSED = 4'd13,
		ST_QUEUE_FULL     = 4'd14
	} status_t;

	typedef enum logic [1:0] {
		SRV_FREE   = 2'd0,
		SRV_CLOSED = 2'd1,
		SRV_BUSY   = 2'd2
	} srv_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_SHIFT,
		S_INS_WRITE,
		S_SCAN,
		S_DEL_SHIFT,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [ACCT_W-1:0] customer_account;
		logic              priority_req;
		logic [SRV_W-1:0]  server_index;
	} req_data_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [SRV_W-1:0]   assigned_server;
		logic [ACCT_W-1:0]  assigned_account;
		logic [COUNT_W-1:0] queue_count;
	} rsp_data_t;

	// One queue slot as kept in the queue memory.
	typedef struct packed {
		logic              prio;
		logic [ACCT_W-1:0] account;
	} qent_t;

	typedef struct packed {
		logic             we;
		logic [SRV_W-1:0] idx;
		srv_state_t       state;
	} srv_wr_t;

	typedef struct packed {
		logic             any_free;
		logic [SRV_W-1:0] free_idx;
		srv_state_t       rd_state;
	} srv_info_t;

endpackage

`default_nettype wire

// ===== src/pqsd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module pqsd_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 25
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/pqsd_srv.sv =====
// Server state table: holds each server's state and finds the lowest free server.
// Depends on pqsd_pkg.
`default_nettype none

module pqsd_srv (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire pqsd_pkg::srv_wr_t         wr,
	input  wire logic [pqsd_pkg::SRV_W-1:0] rd_idx,
	output pqsd_pkg::srv_info_t            info
);
	import pqsd_pkg::*;

	srv_state_t states_q [NUM_SERVERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SERVERS; i++) begin
				states_q[i] <= SRV_FREE;
			end
		end else if (wr.we && ({1'b0, wr.idx} < SRV_LIMIT)) begin
			states_q[wr.idx] <= wr.state;
		end
	end

	// Scan from the top so that the lowest free server wins.
	always_comb begin
		info.any_free = 1'b0;
		info.free_idx = '0;
		for (int i = NUM_SERVERS - 1; i >= 0; i--) begin
			if (states_q[i] == SRV_FREE) begin
				info.any_free = 1'b1;
				info.free_idx = SRV_W'(i);
			end
		end
		info.rd_state = ({1'b0, rd_idx} < SRV_LIMIT) ? states_q[rd_idx] : SRV_FREE;
	end

endmodule

`default_nettype wire

// ===== src/priority_queue_server_dispatch_unit.sv =====
// Priority queue server dispatch unit: top level with request sequencer and result register.
// Depends on pqsd_pkg, pqsd_ram, pqsd_srv and the assertion macro header.
//
// Usage: requests arrive on req (req_valid / req_stall), one result per request
// leaves on rsp (rsp_valid / rsp_stall). A transfer happens at a rising edge with
// valid high and stall low. The queue lives in a 16-entry memory kept in service
// order (priority entries first, arrival order within a level); the server
// states live in flip-flops.
// Server requests, direct assignment, a queue-full or empty result and an
// insert at the tail go from the request transfer to S_DONE, then to the
// output register. A priority insert behind normal entries moves each of them
// up one slot, one memory read and write per cycle. Remove and call-next scan
// the memory one slot per cycle and then close the gap.
// One request is in work at a time; req_stall is high from the transfer until
// the result moves into the output register. A result waiting on a stalled
// receiver does not hold up the next request; a new result then waits in the
// sequencer until rsp is free.
// Reset empties the queue, sets every server free and clears rsp_valid. The
// memory contents are not cleared; only slots below the queue length are read.
`default_nettype none
`include "priority_queue_server_dispatch_unit_assert.svh"

module priority_queue_server_dispatch_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire pqsd_pkg::req_data_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output pqsd_pkg::rsp_data_t      rsp
);
	import pqsd_pkg::*;

	fsm_t              state_q, state_d;
	logic [QCNT_W-1:0] len_q, len_d;
	logic [QCNT_W-1:0] pcnt_q, pcnt_d;
	logic [QIDX_W-1:0] rd_q, rd_d;
	logic [QIDX_W-1:0] pos_q, pos_d;
	req_data_t         req_q, req_d;
	status_t           res_status_q, res_status_d;
	logic [SRV_W-1:0]  res_srv_q, res_srv_d;
	logic [ACCT_W-1:0] res_acct_q, res_acct_d;
	logic              out_valid_q;
	rsp_data_t         out_q;
	logic              out_load;

	logic              mem_we;
	logic [QIDX_W-1:0] mem_waddr;
	qent_t             mem_wdata;
	logic              mem_re;
	logic [QIDX_W-1:0] mem_raddr;
	qent_t             mem_rdata;

	srv_wr_t           srv_wr;
	logic [SRV_W-1:0]  srv_rd_idx;
	srv_info_t         srv_info;

	logic [QCNT_W-1:0] rd_next;
	logic              more_to_read;
	logic              is_call;
	logic              hit;

	pqsd_ram #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH($bits(qent_t))
	) u_queue_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	pqsd_srv u_srv (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (srv_wr),
		.rd_idx(srv_rd_idx),
		.info  (srv_info)
	);

	assign req_stall  = (state_q != S_IDLE);
	assign rsp_valid  = out_valid_q;
	assign rsp        = out_q;
	assign srv_rd_idx = req.server_index;

	assign rd_next      = QCNT_W'(rd_q) + QCNT_W'(1);
	assign more_to_read = (rd_next < len_q);
	assign is_call      = (req_t'(req_q.req_type) == REQ_CALL_NEXT);
	assign hit          = is_call || (mem_rdata.account == req_q.customer_account);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			pcnt_q  <= pcnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q         <= rd_d;
		pos_q        <= pos_d;
		req_q        <= req_d;
		res_status_q <= res_status_d;
		res_srv_q    <= res_srv_d;
		res_acct_q   <= res_acct_d;
		if (out_load) begin
			out_q.status           <= res_status_q;
			out_q.assigned_server  <= res_srv_q;
			out_q.assigned_account <= res_acct_q;
			out_q.queue_count      <= COUNT_W'(len_q);
		end
	end

	always_comb begin
		state_d      = state_q;
		len_d        = len_q;
		pcnt_d       = pcnt_q;
		rd_d         = rd_q;
		pos_d        = pos_q;
		req_d        = req_q;
		res_status_d = res_status_q;
		res_srv_d    = res_srv_q;
		res_acct_d   = res_acct_q;
		out_load     = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = '0;
		mem_wdata    = '0;
		mem_re       = 1'b0;
		mem_raddr    = '0;
		srv_wr       = '{we: 1'b0, idx: '0, state: SRV_FREE};

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_d        = req;
					res_status_d = ST_NOT_FOUND;
					res_srv_d    = '0;
					res_acct_d   = '0;
					state_d      = S_DONE;
					unique case (req_t'(req.req_type)) inside
						REQ_INSERT: begin
							if ((len_q == '0) && srv_info.any_free) begin
								srv_wr       = '{we: 1'b1, idx: srv_info.free_idx, state: SRV_BUSY};
								res_status_d = ST_ASSIGNED;
								res_srv_d    = srv_info.free_idx;
								res_acct_d   = req.customer_account;
							end else if (len_q >= QCNT_W'(QUEUE_DEPTH)) begin
								res_status_d = ST_QUEUE_FULL;
							end else if (!req.priority_req || (pcnt_q == len_q)) begin
								// The new entry belongs at the tail: no slot moves.
								mem_we       = 1'b1;
								mem_waddr    = QIDX_W'(len_q);
								mem_wdata    = '{prio: req.priority_req, account: req.customer_account};
								len_d        = len_q + 1'b1;
								pcnt_d       = pcnt_q + QCNT_W'(req.priority_req);
								res_status_d = ST_QUEUED;
							end else begin
								// Priority entry goes behind the last priority entry;
								// normal entries move up starting from the tail.
								mem_re    = 1'b1;
								mem_raddr = QIDX_W'(len_q - 1'b1);
								rd_d      = QIDX_W'(len_q - 1'b1);
								pos_d     = QIDX_W'(pcnt_q);
								state_d   = S_INS_SHIFT;
							end
						end
						REQ_REMOVE, REQ_CALL_NEXT: begin
							if (len_q == '0) begin
								res_status_d = ST_EMPTY;
							end else if ((req_t'(req.req_type) == REQ_CALL_NEXT) &&
								!srv_info.any_free) begin
								res_status_d = ST_NONE_FREE;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								rd_d      = '0;
								state_d   = S_SCAN;
							end
						end
						REQ_RELEASE: begin
							if ({1'b0, req.server_index} < SRV_LIMIT) begin
								if (srv_info.rd_state == SRV_FREE) begin
									res_status_d = ST_ALREADY_FREE;
								end else if (srv_info.rd_state == SRV_BUSY) begin
									srv_wr       = '{we: 1'b1, idx: req.server_index, state: SRV_FREE};
									res_status_d = ST_RELEASED;
								end else begin
									res_status_d = ST_CLOSED;
								end
							end
						end
						REQ_OPEN: begin
							if ({1'b0, req.server_index} < SRV_LIMIT) begin
								if (srv_info.rd_state == SRV_FREE) begin
									res_status_d = ST_ALREADY_OPEN;
								end else if (srv_info.rd_state == SRV_BUSY) begin
									res_status_d = ST_BUSY;
								end else begin
									srv_wr       = '{we: 1'b1, idx: req.server_index, state: SRV_FREE};
									res_status_d = ST_OPENED;
								end
							end
						end
						REQ_CLOSE: begin
							if ({1'b0, req.server_index} < SRV_LIMIT) begin
								if (srv_info.rd_state == SRV_CLOSED) begin
									res_status_d = ST_ALREADY_CLOSED;
								end else if (srv_info.rd_state == SRV_BUSY) begin
									res_status_d = ST_BUSY;
								end else begin
									srv_wr       = '{we: 1'b1, idx: req.server_index, state: SRV_CLOSED};
									res_status_d = ST_CLOSED_OK;
								end
							end
						end
						default: begin
							res_status_d = ST_NOT_FOUND;
						end
					endcase
				end
			end
			S_INS_SHIFT: begin
				// Slot rd_q arrives from memory and moves up by one while the
				// next lower slot is read; the two addresses never coincide.
				mem_we    = 1'b1;
				mem_waddr = rd_q + 1'b1;
				mem_wdata = mem_rdata;
				if (rd_q == pos_q) begin
					state_d = S_INS_WRITE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = rd_q - 1'b1;
					rd_d      = rd_q - 1'b1;
				end
			end
			S_INS_WRITE: begin
				mem_we       = 1'b1;
				mem_waddr    = pos_q;
				mem_wdata    = '{prio: req_q.priority_req, account: req_q.customer_account};
				len_d        = len_q + 1'b1;
				pcnt_d       = pcnt_q + QCNT_W'(req_q.priority_req);
				res_status_d = ST_QUEUED;
				state_d      = S_DONE;
			end
			S_SCAN: begin
				if (hit) begin
					pcnt_d = pcnt_q - QCNT_W'(mem_rdata.prio);
					if (is_call) begin
						srv_wr       = '{we: 1'b1, idx: srv_info.free_idx, state: SRV_BUSY};
						res_status_d = ST_ASSIGNED;
						res_srv_d    = srv_info.free_idx;
						res_acct_d   = mem_rdata.account;
					end else begin
						res_status_d = ST_REMOVED;
					end
					if (more_to_read) begin
						mem_re    = 1'b1;
						mem_raddr = QIDX_W'(rd_next);
						rd_d      = QIDX_W'(rd_next);
						state_d   = S_DEL_SHIFT;
					end else begin
						len_d   = len_q - 1'b1;
						state_d = S_DONE;
					end
				end else if (more_to_read) begin
					mem_re    = 1'b1;
					mem_raddr = QIDX_W'(rd_next);
					rd_d      = QIDX_W'(rd_next);
				end else begin
					res_status_d = ST_NOT_FOUND;
					state_d      = S_DONE;
				end
			end
			S_DEL_SHIFT: begin
				// Close the gap: slot rd_q moves down by one.
				mem_we    = 1'b1;
				mem_waddr = rd_q - 1'b1;
				mem_wdata = mem_rdata;
				if (more_to_read) begin
					mem_re    = 1'b1;
					mem_raddr = QIDX_W'(rd_next);
					rd_d      = QIDX_W'(rd_next);
				end else begin
					len_d   = len_q - 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !rsp_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`PQSD_ASSERT_IMPL(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "queue memory read and write hit the same slot")
	`PQSD_ASSERT_ALWAYS(a_pcnt_le_len, (pcnt_q <= len_q) && (len_q <= QCNT_W'(QUEUE_DEPTH)), "queue counters out of range")
	`PQSD_ASSERT_IMPL(a_scan_in_range, (state_q == S_SCAN) || (state_q == S_DEL_SHIFT), QCNT_W'(rd_q) < len_q, "scan beyond queue length")
	`PQSD_ASSERT_NEXT(a_len_step, 1'b1, (len_q == $past(len_q)) || (len_q == $past(len_q) + 1'b1) || (len_q == $past(len_q) - 1'b1), "queue length jumped")

endmodule

`default_nettype wire
